// File: rtl/lidar_scan_frame_to_xy_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the lidar scan frame to x/y block
// Shared property forms used by the port-level checker. Each macro expects
// signals named clock and reset in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef LIDAR_SCAN_FRAME_TO_XY_ASSERT_SVH
`define LIDAR_SCAN_FRAME_TO_XY_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define LSXY_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lidar_scan_frame_to_xy: assertion failed");

// Next-cycle implication, disabled while reset is high
`define LSXY_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lidar_scan_frame_to_xy: assertion failed");

`endif

// File: rtl/lsxy_pkg.sv
// ---------------------------------------------------------------------------
// lsxy_pkg
// Constants, types and helper functions for the lidar frame parser and the
// polar to Cartesian conversion.
// ---------------------------------------------------------------------------
package lsxy_pkg;

   // Frame geometry
   localparam int PACKETS_PER_FRAME = 60;
   localparam int PACKET_LEN        = 42;

   // Sync bytes
   localparam logic [7:0] SYNC_A = 8'hFA;
   localparam logic [7:0] SYNC_B = 8'hA0;

   // pi in Q30, for building the sine table
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int ANGLE_W = 9;
   localparam int RANGE_W = 16;
   localparam int POS_W   = 25;
   localparam int TRIG_W  = 15;
   localparam int OFS_W   = 6;

   // Parser phase, one-hot
   typedef enum logic [2:0] {
      PH_HUNT  = 3'b001,
      PH_SYNC2 = 3'b010,
      PH_FRAME = 3'b100
   } phase_type;

   // One reading handed from the parser to the conversion stage
   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [RANGE_W-1:0] range;
   } reading_type;

   // Where a packet offset falls inside the six readings
   typedef struct packed {
      logic       lo;
      logic       hi;
      logic [2:0] idx;
   } slot_type;

   // Folded angle: quarter-wave index and sign
   typedef struct packed {
      logic       neg;
      logic [6:0] idx;
   } fold_type;

   // Quarter-wave sine magnitudes, 0..90 degrees
   typedef logic [90:0][TRIG_W-1:0] sin_tab_type;

   // sin(k deg) in Q1.15, saturated; Q30 Taylor series to x^15
   function automatic logic [TRIG_W-1:0] sin_quarter(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        q;
      x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - signed'(term);
      if (sum < 0) begin
         sum = '0;
      end
      q = (unsigned'(sum) + 64'd16384) >> 15;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return q[TRIG_W-1:0];
   endfunction

   function automatic sin_tab_type build_sin_tab();
      sin_tab_type t;
      for (int k = 0; k <= 90; k++) begin
         t[k] = sin_quarter(k);
      end
      return t;
   endfunction

   localparam sin_tab_type SIN_TAB = build_sin_tab();

   // Map an angle in 0..449 degrees onto the quarter wave
   function automatic fold_type fold_angle(input logic [9:0] d);
      logic [9:0] m;
      fold_type   f;
      m = (d >= 10'd360) ? d - 10'd360 : d;
      if (m <= 10'd90) begin
         f.neg = 1'b0;
         f.idx = m[6:0];
      end else if (m <= 10'd180) begin
         f.neg = 1'b0;
         f.idx = 7'(10'd180 - m);
      end else if (m <= 10'd270) begin
         f.neg = 1'b1;
         f.idx = 7'(m - 10'd180);
      end else begin
         f.neg = 1'b1;
         f.idx = 7'(10'd360 - m);
      end
      return f;
   endfunction

   // Reading slot for a packet offset: low range byte, high range byte
   function automatic slot_type reading_slot(input logic [OFS_W-1:0] o);
      slot_type s;
      s = '0;
      case (o) inside
         6'd6, 6'd12, 6'd18, 6'd24, 6'd30, 6'd36: s.lo = 1'b1;
         default: ;
      endcase
      case (o)
         6'd7:    begin s.hi = 1'b1; s.idx = 3'd0; end
         6'd13:   begin s.hi = 1'b1; s.idx = 3'd1; end
         6'd19:   begin s.hi = 1'b1; s.idx = 3'd2; end
         6'd25:   begin s.hi = 1'b1; s.idx = 3'd3; end
         6'd31:   begin s.hi = 1'b1; s.idx = 3'd4; end
         6'd37:   begin s.hi = 1'b1; s.idx = 3'd5; end
         default: ;
      endcase
      return s;
   endfunction

endpackage

// File: rtl/lidar_scan_frame_to_xy.sv
// A range-high byte accepted on req is held as a reading in the parser's reading register and
// then shows its result on rsp from the output register.
// Throughput: one byte per cycle; the parser register and the output register each hold
// one beat, so bytes keep flowing while one result waits; a second pending one stalls req.
// Only range-high bytes of a valid packet with nonzero angle and range make a beat.
// Reset (synchronous, active high) returns the parser to sync hunting and empties both.
// ---------------------------------------------------------------------------
// lidar_scan_frame_to_xy
// Lidar byte-stream parser with polar to Cartesian conversion of each reading.
// ---------------------------------------------------------------------------
module lidar_scan_frame_to_xy #(
   parameter int PACKETS_PER_FRAME = lsxy_pkg::PACKETS_PER_FRAME,
   parameter int PACKET_LEN        = lsxy_pkg::PACKET_LEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // [24:0] x_pos, [49:25] y_pos, [58:50] angle_deg,
                                    // [74:59] distance, [79:75] zero
);

   logic                   rd_valid;
   logic                   rd_ready;
   lsxy_pkg::reading_type  rd_data;

   // Byte parser and reading register
   lsxy_parser #(
      .PACKETS_PER_FRAME (PACKETS_PER_FRAME),
      .PACKET_LEN        (PACKET_LEN)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rd_valid   (rd_valid),
      .rd_ready   (rd_ready),
      .rd_data    (rd_data)
   );

   // Coordinate conversion and output register
   lsxy_xy u_xy (
      .clock      (clock),
      .reset      (reset),
      .rd_valid   (rd_valid),
      .rd_ready   (rd_ready),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/lsxy_parser.sv
// ---------------------------------------------------------------------------
// lsxy_parser
// Byte-stream parser: sync hunt, packet/offset tracking, header checks and
// range assembly. Registers one reading per nonzero range of a valid packet at a nonzero angle.
// ---------------------------------------------------------------------------
module lsxy_parser #(
   parameter int PACKETS_PER_FRAME = lsxy_pkg::PACKETS_PER_FRAME,
   parameter int PACKET_LEN        = lsxy_pkg::PACKET_LEN
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [lsxy_pkg::BYTE_W-1:0]  req_tdata,
   output logic                         rd_valid,
   input  logic                         rd_ready,
   output lsxy_pkg::reading_type        rd_data
);

   lsxy_pkg::phase_type              phase_ff, phase_in;
   logic [lsxy_pkg::OFS_W-1:0]       offset_ff, offset_in;
   logic [lsxy_pkg::OFS_W-1:0]       pkt_ff, pkt_in;
   logic                             pkt_ok_ff, pkt_ok_in;
   logic [lsxy_pkg::BYTE_W-1:0]      range_lo_ff, range_lo_in;
   logic                             rd_valid_ff, rd_valid_in;
   lsxy_pkg::reading_type            rd_data_ff, rd_data_in;

   logic                             accept;
   logic                             hit;
   lsxy_pkg::reading_type            reading;
   lsxy_pkg::slot_type               slot;
   logic [lsxy_pkg::OFS_W:0]         pkt_next;
   logic [lsxy_pkg::ANGLE_W-1:0]     pkt_x6;

   assign req_tready = !rd_valid_ff || rd_ready;
   assign accept     = req_tvalid && req_tready;
   assign rd_valid   = rd_valid_ff;
   assign rd_data    = rd_data_ff;

   assign slot     = lsxy_pkg::reading_slot(offset_ff);
   assign pkt_next = {1'b0, pkt_ff} + 7'd1;
   assign pkt_x6   = {1'b0, pkt_ff, 2'b00} + {2'b00, pkt_ff, 1'b0};

   // Reading formed when the high range byte arrives
   always_comb begin
      reading.range = {req_tdata, range_lo_ff};
      reading.angle = pkt_x6 + {6'd0, slot.idx};
   end

   // Parser next state
   always_comb begin
      phase_in    = phase_ff;
      offset_in   = offset_ff;
      pkt_in      = pkt_ff;
      pkt_ok_in   = pkt_ok_ff;
      range_lo_in = range_lo_ff;
      hit         = 1'b0;
      case (phase_ff)
         lsxy_pkg::PH_SYNC2: begin
            if (req_tdata == lsxy_pkg::SYNC_B) begin
               phase_in  = lsxy_pkg::PH_FRAME;
               offset_in = 6'd2;
               pkt_in    = '0;
               pkt_ok_in = 1'b1;
            end else begin
               phase_in = lsxy_pkg::PH_HUNT;
            end
         end
         lsxy_pkg::PH_FRAME: begin
            if (offset_ff == 6'd0) begin
               pkt_ok_in = (req_tdata == lsxy_pkg::SYNC_A);
            end else if (offset_ff == 6'd1) begin
               if (req_tdata != lsxy_pkg::SYNC_B + {2'b00, pkt_ff}) begin
                  pkt_ok_in = 1'b0;
               end
            end else if (slot.lo) begin
               range_lo_in = req_tdata;
            end else if (slot.hi) begin
               hit = pkt_ok_ff && (reading.angle != '0) && (reading.range != '0);
            end
            // Packet and frame boundaries
            if (offset_ff == lsxy_pkg::OFS_W'(PACKET_LEN - 1)) begin
               offset_in = '0;
               if (pkt_next >= 7'(PACKETS_PER_FRAME)) begin
                  pkt_in   = '0;
                  phase_in = lsxy_pkg::PH_HUNT;
               end else begin
                  pkt_in = pkt_next[lsxy_pkg::OFS_W-1:0];
               end
            end else begin
               offset_in = offset_ff + 6'd1;
            end
         end
         default: begin
            phase_in = (req_tdata == lsxy_pkg::SYNC_A) ? lsxy_pkg::PH_SYNC2
                                                       : lsxy_pkg::PH_HUNT;
         end
      endcase
   end

   // Reading register control
   always_comb begin
      rd_valid_in = rd_valid_ff;
      rd_data_in  = rd_data_ff;
      if (rd_ready) begin
         rd_valid_in = 1'b0;
      end
      if (accept && hit) begin
         rd_valid_in = 1'b1;
         rd_data_in  = reading;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= lsxy_pkg::PH_HUNT;
         offset_ff   <= '0;
         pkt_ff      <= '0;
         pkt_ok_ff   <= 1'b0;
         range_lo_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            offset_ff   <= offset_in;
            pkt_ff      <= pkt_in;
            pkt_ok_ff   <= pkt_ok_in;
            range_lo_ff <= range_lo_in;
         end
         rd_valid_ff <= rd_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      rd_data_ff <= rd_data_in;
   end

endmodule

// File: rtl/lsxy_xy.sv
// ---------------------------------------------------------------------------
// lsxy_xy
// Polar to Cartesian stage: angle folding, quarter-wave sine lookup, two
// range-by-trig products with symmetric rounding, output register.
// ---------------------------------------------------------------------------
module lsxy_xy (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_valid,
   output logic                   rd_ready,
   input  lsxy_pkg::reading_type  rd_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [79:0]            rsp_tdata  // x_pos, y_pos, angle_deg, distance, zero pad
);

   localparam int PROD_W = 32;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [74:0]                         rsp_data_ff, rsp_data_in;

   lsxy_pkg::fold_type                  cos_fold, sin_fold;
   logic [lsxy_pkg::TRIG_W-1:0]         cos_mag, sin_mag;
   logic [PROD_W-1:0]                   cos_prod, sin_prod;
   logic [lsxy_pkg::POS_W-1:0]          cos_scaled, sin_scaled;
   logic signed [lsxy_pkg::POS_W-1:0]   x_pos, y_pos;
   logic                                load;

   assign rd_ready   = !rsp_valid_ff || rsp_tready;
   assign load       = rd_valid && rd_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

   // Fold both angles onto the quarter wave; cos(a) = sin(a + 90)
   assign cos_fold = lsxy_pkg::fold_angle({1'b0, rd_data.angle} + 10'd90);
   assign sin_fold = lsxy_pkg::fold_angle({1'b0, rd_data.angle});
   assign cos_mag  = lsxy_pkg::SIN_TAB[cos_fold.idx];
   assign sin_mag  = lsxy_pkg::SIN_TAB[sin_fold.idx];

   // Magnitude products, round half up at bit 7
   assign cos_prod   = PROD_W'(rd_data.range) * PROD_W'(cos_mag) + PROD_W'(64);
   assign sin_prod   = PROD_W'(rd_data.range) * PROD_W'(sin_mag) + PROD_W'(64);
   assign cos_scaled = cos_prod[PROD_W-1:7];
   assign sin_scaled = sin_prod[PROD_W-1:7];

   // Apply sign
   assign x_pos = cos_fold.neg ? -signed'(cos_scaled) : signed'(cos_scaled);
   assign y_pos = sin_fold.neg ? -signed'(sin_scaled) : signed'(sin_scaled);

   // Output register control
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {rd_data.range, rd_data.angle, y_pos, x_pos};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: rtl/lsxy_checker.sv
// ---------------------------------------------------------------------------
// lsxy_checker
// Port-level checks for lidar_scan_frame_to_xy, attached by bind.
// ---------------------------------------------------------------------------
`include "lidar_scan_frame_to_xy_assert.svh"

module lsxy_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   // Stalled result beat holds
   `LSXY_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Nothing left on the output right after reset
   `LSXY_ASSERT_NOW(a_rsp_reset, $past(reset), !rsp_tvalid)

   // A new result beat is preceded by an accepted byte
   `LSXY_ASSERT_NOW(a_rsp_cause, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2))

   // With the output empty, the input side is never blocked
   `LSXY_ASSERT_NOW(a_req_open, !rsp_tvalid, req_tready)

endmodule

bind lidar_scan_frame_to_xy lsxy_checker u_lsxy_checker (.*);

// File: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: lidar scan frame to x/y regression
// Feeds a lidar byte stream (line noise, broken sync pairs, then packets 0..17 of
// one frame fed in slices with corrupted packets) into the parser and predicts every
// converted reading with an independent frame tracker and fixed-point sine.
// Results are checked in order, field by field, under several
// sender/receiver idle mixes and one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_LEN    = 1500;
   localparam int DRAIN_WAIT  = 8;

   // One converted reading as carried on rsp_tdata
   typedef struct packed {
      logic signed [lsxy_pkg::POS_W-1:0] x_pos;
      logic signed [lsxy_pkg::POS_W-1:0] y_pos;
      logic [lsxy_pkg::ANGLE_W-1:0]      angle_deg;
      logic [lsxy_pkg::RANGE_W-1:0]      distance;
   } xy_point_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;            // [24:0] x_pos, [49:25] y_pos, [58:50] angle_deg,
                                      // [74:59] distance, [79:75] zero

   logic [7:0]   rx_stream[$];        // bytes waiting to be sent
   xy_point_type xy_expected[$];      // predicted readings, oldest first
   int           mismatch_count = 0;
   int           send_idle_pct  = 0;
   int           stall_pct      = 0;
   int           cycle_count    = 0;

   // Long receiver hold-off
   logic hold_req  = 1'b0;
   logic hold_done = 1'b0;
   int   hold_count = 0;
   logic rx_hold;

   // Frame tracker state
   lsxy_pkg::phase_type frame_phase = lsxy_pkg::PH_HUNT;
   int                  pkt_ofs     = 0;
   logic [5:0]          pkt_num     = '0;
   logic                pkt_ok      = 1'b0;
   logic [7:0]          range_lo    = '0;

   lidar_scan_frame_to_xy u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10ns clock = ~clock;

   // sin(deg) for 0..90 in Q1.15: Q30 Taylor series, truncating steps
   function automatic int sine_q15(input int unsigned deg);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint unsigned q;
      x    = (64'(deg) * lsxy_pkg::PI_Q30 + 64'd90) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      q = (longint'(sum) + 64'd16384) >> 15;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return int'(q);
   endfunction

   // Full-circle sine via quadrant symmetry
   function automatic int sine_deg(input int unsigned deg);
      int unsigned d;
      d = deg % 360;
      if (d <= 90) begin
         return sine_q15(d);
      end else if (d <= 180) begin
         return sine_q15(180 - d);
      end else if (d <= 270) begin
         return -sine_q15(d - 180);
      end
      return -sine_q15(360 - d);
   endfunction

   // range * trig, rounded half up on the magnitude, sign reapplied
   function automatic logic [lsxy_pkg::POS_W-1:0] polar_scale(input int unsigned rng,
                                                             input int trig);
      longint unsigned mag;
      longint unsigned p;
      longint          v;
      mag = (trig < 0) ? longint'(-trig) : longint'(trig);
      p   = (64'(rng) * mag + 64'd64) >> 7;
      v   = (trig < 0) ? -longint'(p) : longint'(p);
      return lsxy_pkg::POS_W'(v);
   endfunction

   // Advance the frame tracker by one byte; queue a reading when one is due
   function automatic void parse_lidar_byte(input logic [7:0] b);
      int           o;
      int unsigned  rng;
      int unsigned  ang;
      xy_point_type pt;
      o = pkt_ofs;
      if (frame_phase == lsxy_pkg::PH_SYNC2) begin
         if (b == lsxy_pkg::SYNC_B) begin
            frame_phase = lsxy_pkg::PH_FRAME;
            pkt_ofs     = 2;
            pkt_num     = '0;
            pkt_ok      = 1'b1;
         end else begin
            frame_phase = lsxy_pkg::PH_HUNT;
         end
         return;
      end
      if (frame_phase != lsxy_pkg::PH_FRAME) begin
         frame_phase = (b == lsxy_pkg::SYNC_A) ? lsxy_pkg::PH_SYNC2 : lsxy_pkg::PH_HUNT;
         return;
      end

      if (o == 0) begin
         pkt_ok = (b == lsxy_pkg::SYNC_A);
      end else if (o == 1) begin
         if (b != 8'(lsxy_pkg::SYNC_B + pkt_num)) begin
            pkt_ok = 1'b0;
         end
      end else if (o >= 6 && o <= 37 && (o - 6) % 6 == 0) begin
         range_lo = b;
      end else if (o >= 7 && o <= 37 && (o - 7) % 6 == 0) begin
         rng = {b, range_lo};
         ang = 6 * pkt_num + (o - 7) / 6;
         if (pkt_ok && ang != 0 && rng != 0) begin
            pt.x_pos     = polar_scale(rng, sine_deg(ang + 90));
            pt.y_pos     = polar_scale(rng, sine_deg(ang));
            pt.angle_deg = lsxy_pkg::ANGLE_W'(ang);
            pt.distance  = lsxy_pkg::RANGE_W'(rng);
            xy_expected.push_back(pt);
         end
      end

      // Packet and frame wrap
      if (o + 1 >= lsxy_pkg::PACKET_LEN) begin
         pkt_ofs = 0;
         pkt_num = pkt_num + 6'd1;
         if (pkt_num >= lsxy_pkg::PACKETS_PER_FRAME) begin
            pkt_num     = '0;
            frame_phase = lsxy_pkg::PH_HUNT;
         end
      end else begin
         pkt_ofs = o + 1;
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns ERROR: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Range value for one reading
   function automatic logic [15:0] pick_range(input bit directed, input int p, input int r);
      int roll;
      if (directed) begin
         if (p == 1 && r == 5) return 16'hFFFF;
         if (p == 5) return 16'h0000;
         case (r)
            0: return 16'hFFFF;
            1: return 16'h0001;
            2: return 16'h0100;
            3: return 16'h00FF;
            4: return 16'h8000;
            default: return 16'($urandom_range(65535, 1));
         endcase
      end
      roll = $urandom_range(99);
      if (roll < 8) return 16'h0000;
      if (roll < 16) return 16'hFFFF;
      if (roll < 22) return 16'($urandom_range(255, 1));
      if (roll < 28) return {8'($urandom_range(255)), 8'h00};
      return 16'($urandom_range(65535));
   endfunction

   // Packets first..first+count-1 of one frame; packet 0 opens with the sync pair
   task automatic push_packets(input bit directed, input int first, input int count);
      logic [7:0]  hdr0;
      logic [7:0]  hdr1;
      logic [7:0]  b;
      logic [15:0] rng[6];
      for (int p = first; p < first + count; p++) begin
         hdr0 = lsxy_pkg::SYNC_A;
         hdr1 = 8'(lsxy_pkg::SYNC_B + p);
         if (directed) begin
            case (p)
               2: hdr0 = 8'hFB;
               3: hdr1 = 8'(lsxy_pkg::SYNC_B + p + 1);
               4: hdr1 = lsxy_pkg::SYNC_B;
               default: ;
            endcase
         end else if ($urandom_range(99) < 6) begin
            hdr0 = 8'($urandom_range(255));
            if (hdr0 == lsxy_pkg::SYNC_A) hdr0 = 8'h05;
         end else if ($urandom_range(99) < 6) begin
            hdr1 = hdr1 ^ 8'(1 << $urandom_range(7));
         end
         for (int r = 0; r < 6; r++) begin
            rng[r] = pick_range(directed, p, r);
         end
         for (int o = 0; o < lsxy_pkg::PACKET_LEN; o++) begin
            if (o == 0) begin
               b = (p == 0) ? lsxy_pkg::SYNC_A : hdr0;
            end else if (o == 1) begin
               b = (p == 0) ? lsxy_pkg::SYNC_B : hdr1;
            end else if (o >= 6 && o <= 37 && (o - 6) % 6 == 0) begin
               b = rng[(o - 6) / 6][7:0];
            end else if (o >= 7 && o <= 37 && (o - 7) % 6 == 0) begin
               b = rng[(o - 7) / 6][15:8];
            end else begin
               b = 8'($urandom_range(255));
            end
            rx_stream.push_back(b);
         end
      end
   endtask

   // Line noise; every 0xFA is followed by a non-0xA0 byte so hunting resumes
   task automatic push_noise(input int count);
      logic [7:0] b;
      logic [7:0] f;
      for (int i = 0; i < count; i++) begin
         b = 8'($urandom_range(255));
         if ($urandom_range(9) == 0) b = lsxy_pkg::SYNC_A;
         rx_stream.push_back(b);
         if (b == lsxy_pkg::SYNC_A) begin
            f = 8'($urandom_range(255));
            if ($urandom_range(3) == 0) f = lsxy_pkg::SYNC_A;
            if (f == lsxy_pkg::SYNC_B) f = lsxy_pkg::SYNC_B ^ 8'h01;
            rx_stream.push_back(f);
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (rx_stream.size() != 0 || req_tvalid || xy_expected.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Byte driver
   always @(posedge clock) begin : byte_drive
      logic go;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_lidar_byte(req_tdata);
            void'(rx_stream.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            go = (rx_stream.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            req_tvalid <= go;
            if (go) begin
               req_tdata <= rx_stream[0];
            end
         end
      end
   end

   // Long hold-off counter
   assign rx_hold = hold_req && !hold_done;

   always @(posedge clock) begin
      if (rx_hold) begin
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_LEN - 1) begin
            hold_done <= 1'b1;
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin : point_check
      xy_point_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (xy_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected beat %h", rsp_tdata));
            end else begin
               want = xy_expected.pop_front();
               if (rsp_tdata[24:0] !== want.x_pos)
                  report_mismatch($sformatf("x_pos %h, expected %h (angle %0d range %0d)",
                     rsp_tdata[24:0], want.x_pos, want.angle_deg, want.distance));
               if (rsp_tdata[49:25] !== want.y_pos)
                  report_mismatch($sformatf("y_pos %h, expected %h (angle %0d range %0d)",
                     rsp_tdata[49:25], want.y_pos, want.angle_deg, want.distance));
               if (rsp_tdata[58:50] !== want.angle_deg)
                  report_mismatch($sformatf("angle_deg %0d, expected %0d",
                     rsp_tdata[58:50], want.angle_deg));
               if (rsp_tdata[74:59] !== want.distance)
                  report_mismatch($sformatf("distance %0d, expected %0d",
                     rsp_tdata[74:59], want.distance));
               if (rsp_tdata[79:75] !== 5'd0)
                  report_mismatch($sformatf("pad bits %b, expected zero", rsp_tdata[79:75]));
            end
         end
         rsp_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Stimulus phases; packets 0..17 of one frame are fed in slices across the phases
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: stray bytes, broken sync pairs, noise, then crafted packets
      @(negedge clock);
      rx_stream.push_back(8'h00);
      rx_stream.push_back(8'hFF);
      rx_stream.push_back(lsxy_pkg::SYNC_B);
      rx_stream.push_back(lsxy_pkg::SYNC_A);
      rx_stream.push_back(lsxy_pkg::SYNC_A);
      rx_stream.push_back(lsxy_pkg::SYNC_A);
      rx_stream.push_back(8'hA1);
      rx_stream.push_back(lsxy_pkg::SYNC_A);
      rx_stream.push_back(8'h20);
      rx_stream.push_back(lsxy_pkg::SYNC_A);
      rx_stream.push_back(8'h55);
      push_noise(30);
      push_packets(1'b1, 0, 6);
      wait_drained();

      // Sender idling
      send_idle_pct = 56;
      stall_pct     = 0;
      push_packets(1'b0, 6, 3);
      wait_drained();

      // Receiver stalling
      send_idle_pct = 0;
      stall_pct     = 56;
      push_packets(1'b0, 9, 3);
      wait_drained();

      // Both sides idling
      send_idle_pct = 29;
      stall_pct     = 29;
      push_packets(1'b0, 12, 3);
      wait_drained();

      // Receiver holds off while bytes keep coming
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_req      = 1'b1;
      push_packets(1'b0, 15, 3);
      wait_drained();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
